/* rtl/core/fbca_pkg.sv */
// ----------------------------------------------------------------------------
// fbca_pkg
// Shared constants, codes and types of the block chain allocator.
// ----------------------------------------------------------------------------
package fbca_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int BLOCK_SIZE = 64;

  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int ENTRY_W = 16;
  localparam int SIZE_W  = 14;

  localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'hFFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFE;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NO_SPACE   = 2'd1,
    STS_START_FREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_ALLOC_END,
    ST_FREE_STEP,
    ST_DONE
  } state_t;

  // Requests from the sequencer to the table.
  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               set_used;
    logic [IDX_W-1:0]   set_addr;
    logic               clr_used;
    logic [IDX_W-1:0]   clr_addr;
  } tbl_req_t;

endpackage

/* rtl/core/fat_block_chain_allocator.sv */
// ----------------------------------------------------------------------------
// fat_block_chain_allocator
// Block chain allocator over a 256-entry allocation table with free count.
// ----------------------------------------------------------------------------
// One command is taken at a time, and in_tready stays low until it is done.
// An allocate checks the free count in its accept cycle, then scans the
// in-use flags one block per cycle from block 0 until enough free blocks are
// linked, and then writes the end mark in a state of its own; a refused
// allocate goes straight to the result. A free reads the chain table once
// per link through its single registered read port, for at most NUM_BLOCKS
// links. The result register then holds the answer while the next command
// is accepted. After reset every block is free at once; no clearing pass is
// needed.
module fat_block_chain_allocator import fbca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // size_bytes[13:0], start_block[21:14], zero fill
  input  logic        in_tuser,   // cmd: 0 allocate, 1 free
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[1:0], first_block[9:2], block_count[18:10],
                                  // free_count[27:19], zero fill
);

  tbl_req_t           tbl_req;
  logic [IDX_W-1:0]   probe_addr;
  logic               probe_free;
  logic [ENTRY_W-1:0] rd_entry;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_first;
  logic [CNT_W-1:0]   res_count;
  logic [CNT_W-1:0]   res_free;

  fbca_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_size    (in_tdata[13:0]),
    .in_start   (in_tdata[21:14]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_first  (res_first),
    .out_count  (res_count),
    .out_free   (res_free),
    .tbl_req    (tbl_req),
    .probe_addr (probe_addr),
    .probe_free (probe_free),
    .rd_entry   (rd_entry)
  );

  fbca_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (tbl_req),
    .probe_addr (probe_addr),
    .probe_free (probe_free),
    .rd_entry   (rd_entry)
  );

  assign out_tdata = {4'b0, res_free, res_count, res_first, res_status};

endmodule

/* rtl/core/fbca_table.sv */
// ----------------------------------------------------------------------------
// fbca_table
// Chain table memory with one write and one registered read port, plus a
// per-entry in-use flag that reset clears, so every entry starts free.
// ----------------------------------------------------------------------------
module fbca_table import fbca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tbl_req_t           req,
  input  logic [IDX_W-1:0]   probe_addr,
  output logic               probe_free,
  output logic [ENTRY_W-1:0] rd_entry
);

  logic [ENTRY_W-1:0]    mem [NUM_BLOCKS];
  logic [ENTRY_W-1:0]    rd_q_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic [NUM_BLOCKS-1:0] used_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r    <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (req.set_used) begin
        used_r[req.set_addr] <= 1'b1;
      end
      if (req.clr_used) begin
        used_r[req.clr_addr] <= 1'b0;
      end
    end
  end

  // An entry whose flag is clear reads as free, whatever the memory holds.
  assign probe_free = ~used_r[probe_addr];
  assign rd_entry   = used_r[rd_addr_r] ? rd_q_r : ENTRY_FREE;

endmodule

/* rtl/core/fbca_seq.sv */
// ----------------------------------------------------------------------------
// fbca_seq
// Command sequencer: scans the table for free blocks on allocate, walks a
// chain on free, keeps the free count and holds the result register.
// ----------------------------------------------------------------------------
module fbca_seq import fbca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [SIZE_W-1:0]  in_size,
  input  logic [IDX_W-1:0]   in_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_first,
  output logic [CNT_W-1:0]   out_count,
  output logic [CNT_W-1:0]   out_free,
  output tbl_req_t           tbl_req,
  output logic [IDX_W-1:0]   probe_addr,
  input  logic               probe_free,
  input  logic [ENTRY_W-1:0] rd_entry
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BLOCKS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  status_t          sts_r, sts_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [1:0]       ostatus_r, ostatus_nxt;
  logic [IDX_W-1:0] ofirst_r, ofirst_nxt;
  logic [CNT_W-1:0] ocount_r, ocount_nxt;
  logic [CNT_W-1:0] ofree_r, ofree_nxt;

  logic             accept;
  logic [CNT_W-1:0] need_in;
  logic             link_stop;

  assign accept  = in_valid && (state_r == ST_IDLE);
  assign need_in = CNT_W'(in_size / BLOCK_SIZE) + CNT_W'(1);
  // A walk ends on the end mark or on a link that points beyond the table.
  assign link_stop = (rd_entry == ENTRY_END) ||
                     (rd_entry[ENTRY_W-1:IDX_W] != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      free_r   <= FULL_CNT;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      free_r   <= free_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r    <= need_nxt;
    cnt_r     <= cnt_nxt;
    idx_r     <= idx_nxt;
    prev_r    <= prev_nxt;
    first_r   <= first_nxt;
    sts_r     <= sts_nxt;
    ostatus_r <= ostatus_nxt;
    ofirst_r  <= ofirst_nxt;
    ocount_r  <= ocount_nxt;
    ofree_r   <= ofree_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    need_nxt    = need_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    prev_nxt    = prev_r;
    first_nxt   = first_r;
    sts_nxt     = sts_r;
    ovalid_nxt  = ovalid_r;
    ostatus_nxt = ostatus_r;
    ofirst_nxt  = ofirst_r;
    ocount_nxt  = ocount_r;
    ofree_nxt   = ofree_r;
    tbl_req     = '0;
    probe_addr  = idx_r;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        probe_addr = in_start;
        if (accept) begin
          cnt_nxt   = '0;
          first_nxt = '0;
          sts_nxt   = STS_OK;
          if (cmd_t'(in_cmd) == CMD_ALLOC) begin
            need_nxt = need_in;
            idx_nxt  = '0;
            if (need_in > free_r) begin
              sts_nxt   = STS_NO_SPACE;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_ALLOC_SCAN;
            end
          end else if (probe_free) begin
            sts_nxt   = STS_START_FREE;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt         = in_start;
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = in_start;
            state_nxt       = ST_FREE_STEP;
          end
        end
      end

      ST_ALLOC_SCAN: begin
        probe_addr = idx_r;
        idx_nxt    = idx_r + IDX_W'(1);
        if (probe_free) begin
          tbl_req.set_used = 1'b1;
          tbl_req.set_addr = idx_r;
          if (cnt_r == '0) begin
            first_nxt = idx_r;
          end else begin
            // Link the previous block of the chain to this one.
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = prev_r;
            tbl_req.wr_data = ENTRY_W'(idx_r);
          end
          prev_nxt = idx_r;
          cnt_nxt  = cnt_r + CNT_W'(1);
          free_nxt = free_r - CNT_W'(1);
          if (cnt_r + CNT_W'(1) == need_r) begin
            state_nxt = ST_ALLOC_END;
          end
        end
      end

      ST_ALLOC_END: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = prev_r;
        tbl_req.wr_data = ENTRY_END;
        state_nxt       = ST_DONE;
      end

      ST_FREE_STEP: begin
        if (rd_entry == ENTRY_FREE) begin
          state_nxt = ST_DONE;
        end else begin
          tbl_req.clr_used = 1'b1;
          tbl_req.clr_addr = idx_r;
          cnt_nxt          = cnt_r + CNT_W'(1);
          if (free_r != FULL_CNT) begin
            free_nxt = free_r + CNT_W'(1);
          end
          if (link_stop || (cnt_r + CNT_W'(1) == FULL_CNT)) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt         = rd_entry[IDX_W-1:0];
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = rd_entry[IDX_W-1:0];
          end
        end
      end

      ST_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = sts_r;
          ofirst_nxt  = (sts_r == STS_OK) ? first_r : '0;
          ocount_nxt  = (sts_r == STS_OK) ? cnt_r : '0;
          ofree_nxt   = free_r;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = ovalid_r;
  assign out_status = ostatus_r;
  assign out_first  = ofirst_r;
  assign out_count  = ocount_r;
  assign out_free   = ofree_r;

endmodule
